// ----- src/hbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// hbpd_pkg
// Shared types and codes for the handle button press decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbpd_pkg;

   localparam int NUM_BUTTONS    = 6;
   localparam int LAMP_COUNT     = 8;
   localparam int PATTERN_W      = 4;
   localparam int PATTERN_SLOTS  = 6;
   localparam int BUTTON_W       = 3;
   localparam int TIMER_W        = 16;
   localparam int THRESHOLD_W    = 16;
   localparam int TICK_W         = 8;
   localparam int CODE_W         = 3;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = PATTERN_W * PATTERN_SLOTS;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASED  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTONS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICK      = 2'd3;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_MIN   = 16'd1000;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd1000;
   localparam logic [TICK_W-1:0]      TICK_SLOW       = 8'd50;
   localparam logic [TICK_W-1:0]      TICK_MEDIUM     = 8'd100;
   localparam logic [TICK_W-1:0]      TICK_FAST       = 8'd200;

   // request operations
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FETCH  = 1'b1;

   // buttons
   localparam logic [BUTTON_W-1:0] BTN_NONE     = 3'd0;
   localparam logic [BUTTON_W-1:0] BTN_LINE_ARC = 3'd1;
   localparam logic [BUTTON_W-1:0] BTN_TEMPLATE = 3'd2;
   localparam logic [BUTTON_W-1:0] BTN_PUSH     = 3'd3;
   localparam logic [BUTTON_W-1:0] BTN_PULL     = 3'd4;
   localparam logic [BUTTON_W-1:0] BTN_DOWN     = 3'd5;
   localparam logic [BUTTON_W-1:0] BTN_UP       = 3'd6;

   // wire-feed commands
   localparam logic [CODE_W-1:0] WELD_NONE       = 3'd0;
   localparam logic [CODE_W-1:0] WELD_START_PUSH = 3'd1;
   localparam logic [CODE_W-1:0] WELD_STOP_PUSH  = 3'd2;
   localparam logic [CODE_W-1:0] WELD_START_PULL = 3'd3;
   localparam logic [CODE_W-1:0] WELD_STOP_PULL  = 3'd4;

   // menu codes
   localparam logic [CODE_W-1:0] MENU_NONE          = 3'd0;
   localparam logic [CODE_W-1:0] MENU_LINE          = 3'd1;
   localparam logic [CODE_W-1:0] MENU_ARC           = 3'd2;
   localparam logic [CODE_W-1:0] MENU_STRAIGHT_TMPL = 3'd3;
   localparam logic [CODE_W-1:0] MENU_ARC_TMPL      = 3'd4;
   localparam logic [CODE_W-1:0] MENU_DOWN          = 3'd5;
   localparam logic [CODE_W-1:0] MENU_UP            = 3'd6;

   typedef struct packed {
      logic                 op;
      logic [PATTERN_W-1:0] di_bits;
   } req_type;

   typedef struct packed {
      logic [CODE_W-1:0]     weld_command;
      logic [CODE_W-1:0]     menu_code;
      logic                  menu_pending;
      logic [LAMP_COUNT-1:0] lamp_bits;
      logic                  lamp_hold;
      logic                  lamp_write;
   } rsp_type;

   typedef struct packed {
      logic [PATTERN_W-1:0]   released_pattern;
      logic [CSR_DATA_W-1:0]  button_patterns;
      logic [THRESHOLD_W-1:0] long_press_threshold;
      logic [TICK_W-1:0]      tick_amount;
   } cfg_type;

endpackage

`default_nettype wire

// ----- src/hbpd_csr.sv -----
// ----------------------------------------------------------------------------
// hbpd_csr
// Configuration registers with write filtering on threshold and tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbpd_csr
   import hbpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   wr_en,
   input  wire logic [CSR_INDEX_W-1:0] wr_index,
   input  wire logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic [THRESHOLD_W-1:0] thr_val;
   logic [TICK_W-1:0]      tick_val;

   assign thr_val  = wr_data[THRESHOLD_W-1:0];
   assign tick_val = wr_data[TICK_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_RELEASED: begin
               cfg_in.released_pattern = wr_data[PATTERN_W-1:0];
            end
            CSR_BUTTONS: begin
               cfg_in.button_patterns = wr_data;
            end
            CSR_THRESHOLD: begin
               if (thr_val >= THRESHOLD_MIN) begin
                  cfg_in.long_press_threshold = thr_val;
               end
            end
            CSR_TICK: begin
               if (tick_val == TICK_SLOW || tick_val == TICK_MEDIUM ||
                   tick_val == TICK_FAST) begin
                  cfg_in.tick_amount = tick_val;
               end
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.released_pattern     <= '0;
         cfg_ff.button_patterns      <= '0;
         cfg_ff.long_press_threshold <= THRESHOLD_RESET;
         cfg_ff.tick_amount          <= TICK_SLOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/hbpd_core.sv -----
// ----------------------------------------------------------------------------
// hbpd_core
// Button state, press timer, lamps, pending menu code and feed command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hbpd_core
   import hbpd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   logic [BUTTON_W-1:0]   held_ff, held_in;
   logic [TIMER_W-1:0]    timer_ff, timer_in;
   logic                  lit_ff, lit_in;
   logic [LAMP_COUNT-1:0] lamp_ff, lamp_in;
   logic                  pend_ff, pend_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [CODE_W-1:0]     weld_ff, weld_in;

   logic [BUTTON_W-1:0]   match;
   logic [TIMER_W:0]      timer_sum;
   logic [TIMER_W-1:0]    timer_sat;
   logic                  is_short;
   logic [2:0]            lamp_idx;
   logic                  wrote;
   logic [CODE_W-1:0]     code_out;

   // lowest-numbered matching button wins
   always_comb begin
      match = BTN_NONE;
      for (int k = NUM_BUTTONS; k >= 1; k--) begin
         if (k <= PATTERN_SLOTS &&
             PATTERN_W'(cfg.button_patterns >> (PATTERN_W * (k - 1))) == item.di_bits) begin
            match = BUTTON_W'(k);
         end
      end
   end

   assign timer_sum = {1'b0, timer_ff} + (TIMER_W + 1)'(cfg.tick_amount);
   assign timer_sat = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
   assign is_short  = timer_ff < cfg.long_press_threshold;

   always_comb begin
      held_in  = held_ff;
      timer_in = timer_ff;
      lit_in   = lit_ff;
      lamp_in  = lamp_ff;
      pend_in  = pend_ff;
      code_in  = code_ff;
      weld_in  = weld_ff;
      wrote    = 1'b0;
      code_out = MENU_NONE;
      lamp_idx = '0;
      if (item.op == OP_FETCH) begin
         code_in = MENU_NONE;
         if (pend_ff) begin
            code_out = code_ff;
            pend_in  = 1'b0;
            held_in  = BTN_NONE;
         end
      end else if (item.di_bits == cfg.released_pattern) begin
         lit_in = 1'b0;
         if (held_ff == BTN_NONE) begin
            weld_in = WELD_NONE;
         end else begin
            lamp_in  = '0;
            wrote    = 1'b1;
            timer_in = '0;
            held_in  = BTN_NONE;
            case (held_ff)
               BTN_LINE_ARC: begin
                  code_in = is_short ? MENU_LINE : MENU_ARC;
                  pend_in = 1'b1;
               end
               BTN_TEMPLATE: begin
                  code_in = is_short ? MENU_STRAIGHT_TMPL : MENU_ARC_TMPL;
                  pend_in = 1'b1;
               end
               BTN_PUSH: weld_in = WELD_STOP_PUSH;
               BTN_PULL: weld_in = WELD_STOP_PULL;
               BTN_DOWN: begin
                  code_in = MENU_DOWN;
                  pend_in = 1'b1;
               end
               BTN_UP: begin
                  code_in = MENU_UP;
                  pend_in = 1'b1;
               end
               default: begin
                  pend_in = pend_ff;
               end
            endcase
         end
      end else begin
         if (match != BTN_NONE) begin
            held_in = match;
         end
         lamp_idx = 3'(4'(LAMP_COUNT) - {1'b0, held_in});
         if (held_in != BTN_NONE && !lit_ff) begin
            lit_in  = 1'b1;
            lamp_in = lamp_ff | (LAMP_COUNT'(1) << lamp_idx);
            wrote   = 1'b1;
         end
         case (held_in)
            BTN_LINE_ARC, BTN_TEMPLATE: begin
               timer_in = timer_sat;
               weld_in  = WELD_NONE;
            end
            BTN_PUSH: weld_in = WELD_START_PUSH;
            BTN_PULL: weld_in = WELD_START_PULL;
            BTN_DOWN, BTN_UP: weld_in = WELD_NONE;
            default: begin
               weld_in = weld_ff;
            end
         endcase
      end
   end

   always_comb begin
      result.weld_command = (item.op == OP_FETCH) ? WELD_NONE : weld_in;
      result.menu_code    = code_out;
      result.menu_pending = pend_in;
      result.lamp_bits    = lamp_in;
      result.lamp_hold    = lit_in;
      result.lamp_write   = wrote;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= BTN_NONE;
         timer_ff <= '0;
         lit_ff   <= 1'b0;
         lamp_ff  <= '0;
         pend_ff  <= 1'b0;
         code_ff  <= MENU_NONE;
         weld_ff  <= WELD_NONE;
      end else if (fire) begin
         held_ff  <= held_in;
         timer_ff <= timer_in;
         lit_ff   <= lit_in;
         lamp_ff  <= lamp_in;
         pend_ff  <= pend_in;
         code_ff  <= code_in;
         weld_ff  <= weld_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/handle_button_press_decoder_top.sv -----
// ----------------------------------------------------------------------------
// handle_button_press_decoder_top
// Handle button decoder: request register, decode logic, response register.
// ----------------------------------------------------------------------------
// A request is a sample of the four handle lines or a fetch of the pending
// menu code. Each request yields exactly one response, and one request is
// taken every cycle while req_stall is low: the request register feeds the
// decode logic and its state registers, which write the response register in
// the same cycle. A response waiting in the response register does not hold
// off the next request while the request register has room. Configuration
// registers are written through the csr port, which is always ready; write
// them only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module handle_button_press_decoder_top
   import hbpd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;

   logic    out_free;
   logic    fire;
   logic    accept;
   cfg_type cfg;
   rsp_type result;

   assign csr_ready = 1'b1;

   hbpd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   hbpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("decoded request did not reach the response register");

   a_sample_no_menu: assert property (@(posedge clock) disable iff (reset)
      fire && in_data_ff.op == OP_SAMPLE |=> rsp_data.menu_code == MENU_NONE)
      else $error("sample request returned a menu code");

   a_fetch_no_write: assert property (@(posedge clock) disable iff (reset)
      fire && in_data_ff.op == OP_FETCH |=>
         !rsp_data.lamp_write && rsp_data.weld_command == WELD_NONE)
      else $error("fetch request touched lamps or feed command");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lamp_write && !rsp_data.lamp_hold |->
         rsp_data.lamp_bits == '0)
      else $error("lamp release left lamps lit");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the handle button press decoder. A short table of
// directed requests and register writes runs first, then several phases of
// random press / release / fetch sequences under different register
// settings. Responses are checked field by field against an in-bench model
// or a fixed quiet response, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import hbpd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 4;
   localparam int NUM_PHASES   = 6;
   localparam int PHASE_ITEMS  = 250;
   localparam int NUM_ROWS     = 32;
   localparam int HOLD_CYCLES  = 200;

   localparam rsp_type RSP_QUIET = '{WELD_NONE, MENU_NONE, 1'b0, 8'h00, 1'b0, 1'b0};

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
      req_type                req;
      logic                   typed;
      rsp_type                want;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // decoder model state
   cfg_type               cfg;
   logic [BUTTON_W-1:0]   cur_button;
   logic [TIMER_W-1:0]    hold_time;
   logic                  lamp_lit;
   logic [LAMP_COUNT-1:0] lamp_image;
   logic                  code_waiting;
   logic [CODE_W-1:0]     code_value;
   logic [CODE_W-1:0]     feed_cmd;

   rsp_type      decoded_rsps[$];
   plan_row_type plan [NUM_ROWS];
   int           err_count   = 0;
   int           cycle_count = 0;
   int           items_sent  = 0;
   int           hold_count  = 0;
   bit           sender_gaps   = 1'b1;
   bit           receiver_gaps = 1'b1;

   handle_button_press_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic void clear_decoder();
      cfg.released_pattern     = '0;
      cfg.button_patterns      = '0;
      cfg.long_press_threshold = THRESHOLD_RESET;
      cfg.tick_amount          = TICK_SLOW;
      cur_button   = BTN_NONE;
      hold_time    = '0;
      lamp_lit     = 1'b0;
      lamp_image   = '0;
      code_waiting = 1'b0;
      code_value   = MENU_NONE;
      feed_cmd     = WELD_NONE;
   endfunction

   function automatic rsp_type decode_request(input req_type item);
      rsp_type             out;
      logic [BUTTON_W-1:0] hit;
      logic [TIMER_W:0]    sum;
      logic                wrote;
      int                  s;
      out   = RSP_QUIET;
      wrote = 1'b0;
      if (item.op == OP_SAMPLE) begin
         if (item.di_bits == cfg.released_pattern) begin
            lamp_lit = 1'b0;
            if (cur_button == BTN_NONE) begin
               feed_cmd = WELD_NONE;
            end else begin
               lamp_image = '0;
               wrote      = 1'b1;
               case (cur_button)
                  BTN_LINE_ARC: begin
                     code_value   = (hold_time < cfg.long_press_threshold) ?
                                    MENU_LINE : MENU_ARC;
                     code_waiting = 1'b1;
                  end
                  BTN_TEMPLATE: begin
                     code_value   = (hold_time < cfg.long_press_threshold) ?
                                    MENU_STRAIGHT_TMPL : MENU_ARC_TMPL;
                     code_waiting = 1'b1;
                  end
                  BTN_PUSH: feed_cmd = WELD_STOP_PUSH;
                  BTN_PULL: feed_cmd = WELD_STOP_PULL;
                  BTN_DOWN: begin
                     code_value   = MENU_DOWN;
                     code_waiting = 1'b1;
                  end
                  BTN_UP: begin
                     code_value   = MENU_UP;
                     code_waiting = 1'b1;
                  end
                  default: ;
               endcase
               hold_time  = '0;
               cur_button = BTN_NONE;
            end
         end else begin
            // lowest-numbered matching button wins
            hit = BTN_NONE;
            for (s = PATTERN_SLOTS; s >= 1; s--) begin
               if (s <= NUM_BUTTONS &&
                   cfg.button_patterns[PATTERN_W*(s-1) +: PATTERN_W] == item.di_bits)
                  hit = BUTTON_W'(s);
            end
            if (hit != BTN_NONE) cur_button = hit;
            if (cur_button != BTN_NONE && !lamp_lit) begin
               lamp_lit   = 1'b1;
               lamp_image = lamp_image |
                            (LAMP_COUNT'(1) << ((LAMP_COUNT - int'(cur_button)) & 7));
               wrote      = 1'b1;
            end
            case (cur_button)
               BTN_LINE_ARC, BTN_TEMPLATE: begin
                  sum       = {1'b0, hold_time} + (TIMER_W+1)'(cfg.tick_amount);
                  hold_time = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];
                  feed_cmd  = WELD_NONE;
               end
               BTN_PUSH:        feed_cmd = WELD_START_PUSH;
               BTN_PULL:        feed_cmd = WELD_START_PULL;
               BTN_DOWN, BTN_UP: feed_cmd = WELD_NONE;
               default: ;
            endcase
         end
         out.weld_command = feed_cmd;
      end else begin
         if (code_waiting) begin
            out.menu_code = code_value;
            code_waiting  = 1'b0;
            cur_button    = BTN_NONE;
         end
         code_value = MENU_NONE;
      end
      out.menu_pending = code_waiting;
      out.lamp_bits    = lamp_image;
      out.lamp_hold    = lamp_lit;
      out.lamp_write   = wrote;
      return out;
   endfunction

   function automatic plan_row_type sample_row(input logic [PATTERN_W-1:0] di);
      plan_row_type row;
      row        = '0;
      row.kind   = ROW_REQ;
      row.req.op = OP_SAMPLE;
      row.req.di_bits = di;
      return row;
   endfunction

   function automatic plan_row_type fetch_row();
      plan_row_type row;
      row        = '0;
      row.kind   = ROW_REQ;
      row.req.op = OP_FETCH;
      return row;
   endfunction

   function automatic plan_row_type quiet_row(input logic op,
                                              input logic [PATTERN_W-1:0] di);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_REQ;
      row.req   = '{op, di};
      row.typed = 1'b1;
      row.want  = RSP_QUIET;
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_INDEX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] wdata);
      plan_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.index = index;
      row.wdata = wdata;
      return row;
   endfunction

   task automatic send_req(input req_type item, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      while (sender_gaps && ($urandom_range(0, 99) < 23)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = decode_request(item);
      if (typed) predicted = typed_rsp;
      decoded_rsps = {decoded_rsps, predicted};
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_sample(input logic [PATTERN_W-1:0] di);
      send_req('{OP_SAMPLE, di}, 1'b0, RSP_QUIET);
   endtask

   task automatic send_fetch();
      send_req('{OP_FETCH, PATTERN_W'($urandom)}, 1'b0, RSP_QUIET);
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      while (decoded_rsps.size() != 0) @(negedge clock);
   endtask

   task automatic wait_idle();
      wait_empty();
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] wdata);
      logic [THRESHOLD_W-1:0] thr;
      logic [TICK_W-1:0]      tick;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= wdata;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thr  = wdata[THRESHOLD_W-1:0];
      tick = wdata[TICK_W-1:0];
      case (index)
         CSR_RELEASED:  cfg.released_pattern = wdata[PATTERN_W-1:0];
         CSR_BUTTONS:   cfg.button_patterns  = wdata;
         CSR_THRESHOLD: if (thr >= THRESHOLD_MIN) cfg.long_press_threshold = thr;
         CSR_TICK: begin
            if (tick == TICK_SLOW || tick == TICK_MEDIUM || tick == TICK_FAST)
               cfg.tick_amount = tick;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic check_rsp(input rsp_type got);
      rsp_type want;
      if (decoded_rsps.size() == 0) begin
         err_count++;
         if (err_count <= 10) $display("response with none outstanding: %h", got);
      end else begin
         want = decoded_rsps.pop_front();
         if (got.weld_command !== want.weld_command || got.menu_code !== want.menu_code ||
             got.menu_pending !== want.menu_pending || got.lamp_bits !== want.lamp_bits ||
             got.lamp_hold !== want.lamp_hold || got.lamp_write !== want.lamp_write) begin
            err_count++;
            if (err_count <= 10)
               $display({"mismatch weld %0d/%0d menu %0d/%0d pend %0b/%0b",
                         " lamps %h/%h hold %0b/%0b wr %0b/%0b"},
                        want.weld_command, got.weld_command, want.menu_code, got.menu_code,
                        want.menu_pending, got.menu_pending, want.lamp_bits, got.lamp_bits,
                        want.lamp_hold, got.lamp_hold, want.lamp_write, got.lamp_write);
         end
      end
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_rsp(rsp_data);
      end
   end

   // receiver side, with a long hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            rsp_stall <= 1'b1;
            hold_count--;
         end else begin
            rsp_stall <= receiver_gaps && ($urandom_range(0, 99) < 23);
         end
      end
   end

   initial begin
      int                      phase;
      int                      start;
      int                      j;
      int                      k;
      int                      n;
      int                      s;
      bit                      hold_done;
      bit                      pause_done;
      logic [PATTERN_W-1:0]    rel;
      logic [PATTERN_W-1:0]    pat;
      logic [CSR_DATA_W-1:0]   pats;
      logic [THRESHOLD_W-1:0]  thr;
      logic [TICK_W-1:0]       tick;

      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_RELEASED;
      csr_wdata = '0;
      clear_decoder();

      plan = '{
         quiet_row(OP_SAMPLE, 4'h0),
         quiet_row(OP_FETCH, 4'h0),
         quiet_row(OP_SAMPLE, 4'hF),
         // button 5 shares button 1's pattern, button 6 shares the released one
         csr_row(CSR_BUTTONS, 24'h014321),
         sample_row(4'h1),
         sample_row(4'h9),
         sample_row(4'h3),
         sample_row(4'h0),
         sample_row(4'h4),
         sample_row(4'h0),
         sample_row(4'h1),
         sample_row(4'h0),
         fetch_row(),
         csr_row(CSR_THRESHOLD, 24'd999),
         csr_row(CSR_TICK, 24'd7),
         csr_row(CSR_TICK, 24'(TICK_FAST)),
         sample_row(4'h2),
         sample_row(4'h2),
         sample_row(4'h2),
         sample_row(4'h2),
         sample_row(4'h2),
         sample_row(4'h0),
         fetch_row(),
         // fetch while another button is held, then release with nothing held
         sample_row(4'h1),
         sample_row(4'h0),
         sample_row(4'h3),
         fetch_row(),
         sample_row(4'h0),
         csr_row(CSR_RELEASED, 24'hF),
         sample_row(4'h0),
         sample_row(4'hF),
         fetch_row()
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            wait_idle();
            csr_write(plan[i].index, plan[i].wdata);
         end else begin
            send_req(plan[i].req, plan[i].typed, plan[i].want);
         end
      end

      hold_done  = 1'b0;
      pause_done = 1'b0;
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         sender_gaps   = (phase != 3);
         receiver_gaps = (phase != 3);

         if (phase == 0 || phase == 2) rel = 4'h0;
         else if (phase == 1 || phase == 3) rel = 4'hF;
         else rel = PATTERN_W'($urandom);

         if (phase == 2) begin
            pats = '1;
         end else if (phase == 3) begin
            pats = '0;
         end else begin
            for (s = 0; s < PATTERN_SLOTS; s++) begin
               do pat = PATTERN_W'($urandom); while (pat == rel);
               pats[PATTERN_W*s +: PATTERN_W] = pat;
            end
         end

         if (phase == 0) thr = THRESHOLD_MIN;
         else if (phase == 4) thr = '1;
         else thr = THRESHOLD_W'($urandom_range(1000, 2000));

         case ($urandom_range(0, 2))
            0:       tick = TICK_SLOW;
            1:       tick = TICK_MEDIUM;
            default: tick = TICK_FAST;
         endcase
         if (phase == 0) tick = TICK_SLOW;
         if (phase == 4) tick = TICK_FAST;

         // writes that should be dropped, then the real settings
         csr_write(CSR_THRESHOLD, {8'($urandom), 16'($urandom_range(0, 999))});
         csr_write(CSR_TICK, {16'($urandom), 8'($urandom)});
         csr_write(CSR_RELEASED, {20'($urandom), rel});
         csr_write(CSR_BUTTONS, pats);
         csr_write(CSR_THRESHOLD, {8'($urandom), thr});
         csr_write(CSR_TICK, {16'($urandom), tick});

         start = items_sent;
         if (phase == 4) begin
            // hold long enough to saturate the press timer
            repeat (340) send_sample(cfg.button_patterns[PATTERN_W-1:0]);
            send_sample(cfg.released_pattern);
            send_fetch();
         end

         while (items_sent - start < PHASE_ITEMS) begin
            if (phase == 1 && !hold_done && items_sent - start > 40) begin
               hold_count = HOLD_CYCLES;
               hold_done  = 1'b1;
            end
            if (phase == 2 && !pause_done && items_sent - start > 100) begin
               wait_empty();
               @(negedge clock);
               pause_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 75) begin
               k   = $urandom_range(1, NUM_BUTTONS);
               pat = cfg.button_patterns[PATTERN_W*(k-1) +: PATTERN_W];
               n   = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) :
                                                    $urandom_range(1, 12);
               for (j = 0; j < n; j++) begin
                  if ($urandom_range(0, 9) == 0) send_sample(PATTERN_W'($urandom));
                  else send_sample(pat);
               end
               send_sample(cfg.released_pattern);
               if ($urandom_range(0, 3) == 0) send_sample(cfg.released_pattern);
               if ($urandom_range(0, 9) < 7) send_fetch();
            end else begin
               repeat ($urandom_range(1, 4))
                  send_req('{1'($urandom), PATTERN_W'($urandom)}, 1'b0, RSP_QUIET);
            end
         end
      end

      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      wait_idle();
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
